@@ hw/rtl/abfa_pkg.sv @@
// Package for the A/B feed arbiter: field widths, word layouts, op and register codes, replace rule.
// No dependencies.
`default_nettype none
package abfa_pkg;
  localparam int SeqW   = 48;
  localparam int EvW    = 44;
  localparam int RecvW  = 52;
  localparam int HndW   = 16;
  localparam int ClkW   = 32;
  localparam int WaitW  = 10;
  localparam int MaxOut = 64;
  localparam int WINDOW = 64;
  localparam int InDataW  = 216;  // 48+48+44+52+1+16 = 209, padded to bytes
  localparam int OutDataW = 160;  // 48+48+44+1+16 = 157, padded to bytes
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] RegStartSeq  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegPeerWait  = 1'b1;
  localparam logic OpUpdate = 1'b0;
  localparam logic OpTick   = 1'b1;
  localparam logic LineA    = 1'b0;

  typedef struct packed {
    logic [SeqW-1:0]  fseq;
    logic [EvW-1:0]   ev_time;
    logic [RecvW-1:0] recv_ts;
    logic             line;
    logic [HndW-1:0]  handle;
    logic [ClkW-1:0]  seen;
  } slot_t;

  // Replace rule for a duplicate copy
  function automatic logic new_wins(input logic [EvW-1:0] ev_n, input logic [RecvW-1:0] rv_n,
                                    input logic ln_n, input slot_t old);
    logic r;
    begin
      r = 1'b0;
      if (ev_n > old.ev_time) r = 1'b1;
      else if (ev_n == old.ev_time && rv_n < old.recv_ts) r = 1'b1;
      else if (ev_n == old.ev_time && rv_n == old.recv_ts)
        r = (old.line != LineA) && (ln_n == LineA);
      new_wins = r;
    end
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/ab_feed_arbiter_reorder.sv @@
// Top level of the A/B feed arbiter with in-order release. Depends on abfa_pkg.
// An update passes S_UPD_RD and S_UPD_WR, a tick goes to S_SCAN, which skips empty slots;
// S_HEAD_RD or S_EMIT_RD reads a slot, S_EMIT fills the output register once it is free, and
// each further word of a run passes S_EMIT_RD, S_EMIT. A step that releases nothing leaves
// from S_EMIT, or from S_SCAN if the window is empty. One step at a time: input ready only
// when idle, output register empty. Reset empties all slots, expected seq 1, wait 5, clock 0.
`default_nettype none
module ab_feed_arbiter_reorder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // tdata: seq, first id, event time, receive time, feed, payload handle, zero pad
  input  wire logic [abfa_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: op
  input  wire logic s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tdata: sequence, first id, event time, feed, handle, zero pad
  output logic [abfa_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: gap
  output logic      m_axis_tuser,
  output logic      m_axis_tlast,
  input  wire logic cfg_we_i,
  input  wire logic [abfa_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [abfa_pkg::CfgDataW-1:0] cfg_data_i
);
  import abfa_pkg::*;
  localparam int IdxW = $clog2(WINDOW);
  localparam int CntW = $clog2(WINDOW + 1);
  localparam int NW   = $clog2(MaxOut + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD_RD, S_UPD_WR, S_SCAN, S_HEAD_RD, S_EMIT_RD, S_EMIT
  } state_e;

  state_e state_q;
  slot_t mem [WINDOW];
  slot_t rd_q;
  logic [WINDOW-1:0] valid_q;
  logic [SeqW-1:0] exp_q;
  logic [ClkW-1:0] clk_ms_q;
  logic [IdxW-1:0] head_q, idx_q, rd_addr, head_nx;
  logic [CntW-1:0] k_q;
  logic [NW-1:0] n_q;
  logic gap_q;
  logic [WaitW-1:0] wait_q;
  logic [InDataW-1:0] in_q;
  logic rd_en;
  logic hold_head, emit_go, run_end;

  logic [SeqW-1:0] i_seq, i_fseq;
  logic [EvW-1:0] i_ev;
  logic [RecvW-1:0] i_rv;
  logic i_ln;
  logic [HndW-1:0] i_hnd;
  logic [SeqW-1:0] off;
  assign i_seq  = in_q[SeqW-1:0];
  assign i_fseq = in_q[2*SeqW-1:SeqW];
  assign i_ev   = in_q[2*SeqW+EvW-1:2*SeqW];
  assign i_rv   = in_q[2*SeqW+EvW+RecvW-1:2*SeqW+EvW];
  assign i_ln   = in_q[2*SeqW+EvW+RecvW];
  assign i_hnd  = in_q[2*SeqW+EvW+RecvW+HndW:2*SeqW+EvW+RecvW+1];
  assign off    = i_seq - exp_q;

  logic [IdxW-1:0] scan_idx;
  assign scan_idx = head_q + k_q[IdxW-1:0];
  assign head_nx  = head_q + 1'b1;

  assign hold_head = (n_q == '0) && !gap_q && ((clk_ms_q - rd_q.seen) < ClkW'(wait_q));
  assign emit_go   = (state_q == S_EMIT) && !hold_head && (!m_axis_tvalid || m_axis_tready);
  assign run_end   = !valid_q[head_nx] || n_q == NW'(MaxOut - 1);

  assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;

  always_comb begin
    rd_en = 1'b0;
    rd_addr = head_q;
    case (state_q)
      S_IDLE: begin
        rd_en = s_axis_tvalid && s_axis_tready && s_axis_tuser == OpUpdate;
        rd_addr = head_q + s_axis_tdata[IdxW-1:0] - exp_q[IdxW-1:0];
      end
      S_HEAD_RD, S_EMIT_RD: rd_en = 1'b1;
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem[rd_addr];
    if (state_q == S_UPD_WR && off < SeqW'(WINDOW) &&
        (!valid_q[idx_q] || new_wins(i_ev, i_rv, i_ln, rd_q))) begin
      mem[idx_q] <= '{fseq: i_fseq, ev_time: i_ev, recv_ts: i_rv, line: i_ln,
                      handle: i_hnd, seen: valid_q[idx_q] ? rd_q.seen : clk_ms_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      exp_q <= SeqW'(1);
      clk_ms_q <= '0;
      head_q <= '0;
      idx_q <= '0;
      k_q <= '0;
      n_q <= '0;
      gap_q <= 1'b0;
      wait_q <= WaitW'(5);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit_go) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegStartSeq) begin
          exp_q <= cfg_data_i;
          valid_q <= '0;
          head_q <= '0;
        end else if (cfg_idx_i == RegPeerWait) begin
          wait_q <= cfg_data_i[WaitW-1:0];
        end
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            in_q <= s_axis_tdata;
            idx_q <= rd_addr;
            k_q <= '0;
            if (s_axis_tuser == OpTick) begin
              clk_ms_q <= clk_ms_q + 1'b1;
              state_q <= S_SCAN;
            end else begin
              state_q <= S_UPD_RD;
            end
          end
        end
        S_UPD_RD: state_q <= S_UPD_WR;
        S_UPD_WR: begin
          if (off < SeqW'(WINDOW)) valid_q[idx_q] <= 1'b1;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (k_q == CntW'(WINDOW)) begin
            state_q <= S_IDLE;
          end else if (valid_q[scan_idx]) begin
            n_q <= '0;
            if (k_q == '0) begin
              state_q <= S_HEAD_RD;
            end else begin
              exp_q <= exp_q + SeqW'(k_q);
              head_q <= scan_idx;
              gap_q <= 1'b1;
              state_q <= S_EMIT_RD;
            end
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_HEAD_RD: begin
          gap_q <= 1'b0;
          state_q <= S_EMIT;
        end
        S_EMIT_RD: state_q <= S_EMIT;
        S_EMIT: begin
          if (hold_head) begin
            state_q <= S_IDLE;
          end else if (emit_go) begin
            m_axis_tdata <= OutDataW'({rd_q.handle, rd_q.line, rd_q.ev_time,
                                       rd_q.fseq, exp_q});
            m_axis_tuser <= gap_q;
            m_axis_tlast <= run_end;
            valid_q[head_q] <= 1'b0;
            exp_q <= exp_q + 1'b1;
            head_q <= head_nx;
            n_q <= n_q + 1'b1;
            state_q <= run_end ? S_IDLE : S_EMIT_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ verif/abfa_checker.sv @@
// Checker for the A/B feed arbiter: watches both stream channels and the config port,
// predicts the released words in sequence order and compares them field by field.
// Depends on abfa_pkg.
`timescale 1ns / 1ps
module abfa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [abfa_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [abfa_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          m_axis_tuser,
  input  logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [abfa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [abfa_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            pending_o,
  output int                            errors_o,
  output int                            released_o
);
  import abfa_pkg::*;

  typedef struct {
    logic [SeqW-1:0] seq;
    logic [SeqW-1:0] fseq;
    logic [EvW-1:0]  ev;
    logic            line;
    logic [HndW-1:0] hnd;
    logic            gap;
    logic            last;
  } release_t;

  release_t         release_q[$];
  bit               held[WINDOW];
  logic [SeqW-1:0]  h_fseq[WINDOW];
  logic [EvW-1:0]   h_ev[WINDOW];
  logic [RecvW-1:0] h_rv[WINDOW];
  logic             h_line[WINDOW];
  logic [HndW-1:0]  h_hnd[WINDOW];
  logic [ClkW-1:0]  h_seen[WINDOW];
  logic [SeqW-1:0]  next_seq;
  logic [ClkW-1:0]  ms_now;
  logic [WaitW-1:0] hold_ms;
  int               head;

  assign pending_o = release_q.size();

  function automatic void resync(input logic [SeqW-1:0] s);
    for (int i = 0; i < WINDOW; i++) held[i] = 1'b0;
    head = 0;
    next_seq = s;
  endfunction

  function automatic void admit(input logic [InDataW-1:0] d);
    logic [SeqW-1:0]  off;
    logic [EvW-1:0]   ev;
    logic [RecvW-1:0] rv;
    logic             ln;
    int               idx;
    bit               take;
    off = d[47:0] - next_seq;
    ev = d[139:96];
    rv = d[191:140];
    ln = d[192];
    if (off >= WINDOW) return;
    idx = (head + int'(off)) % WINDOW;
    if (!held[idx]) begin
      take = 1;
      h_seen[idx] = ms_now;
    end else if (ev > h_ev[idx]) take = 1;
    else if (ev == h_ev[idx] && rv < h_rv[idx]) take = 1;
    else if (ev == h_ev[idx] && rv == h_rv[idx]) take = (h_line[idx] != LineA) && (ln == LineA);
    else take = 0;
    if (take) begin
      held[idx] = 1'b1;
      h_fseq[idx] = d[95:48];
      h_ev[idx] = ev;
      h_rv[idx] = rv;
      h_line[idx] = ln;
      h_hnd[idx] = d[208:193];
    end
  endfunction

  function automatic void release_run(input logic gap);
    release_t r;
    int n;
    n = 0;
    while (n < MaxOut && held[head]) begin
      r.seq = next_seq;
      r.fseq = h_fseq[head];
      r.ev = h_ev[head];
      r.line = h_line[head];
      r.hnd = h_hnd[head];
      r.gap = gap;
      r.last = 1'b0;
      release_q.insert(release_q.size(), r);
      held[head] = 1'b0;
      next_seq = next_seq + 1'b1;
      head = (head + 1) % WINDOW;
      n++;
    end
    if (n > 0) release_q[release_q.size()-1].last = 1'b1;
  endfunction

  function automatic void step(input logic op, input logic [InDataW-1:0] d);
    int k;
    if (op == OpTick) ms_now = ms_now + 1'b1;
    else admit(d);
    for (k = 0; k < WINDOW; k++)
      if (held[(head + k) % WINDOW]) break;
    if (k == WINDOW) return;
    if (k == 0) begin
      if (ms_now - h_seen[head] >= ClkW'(hold_ms)) release_run(1'b0);
      return;
    end
    next_seq = next_seq + SeqW'(k);
    head = (head + k) % WINDOW;
    release_run(1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    release_t e;
    if (!rst_ni) begin
      release_q.delete();
      resync(SeqW'(1));
      ms_now = '0;
      hold_ms = WaitW'(5);
      errors_o = 0;
      released_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        released_o++;
        if (release_q.size() == 0) begin
          $error("unexpected word seq=%0d", m_axis_tdata[47:0]);
          errors_o++;
        end else begin
          e = release_q.pop_front();
          if (m_axis_tdata[47:0] !== e.seq) begin
            $error("out_seq exp %0d got %0d", e.seq, m_axis_tdata[47:0]); errors_o++;
          end
          if (m_axis_tdata[95:48] !== e.fseq) begin
            $error("out_first_seq exp %0d got %0d", e.fseq, m_axis_tdata[95:48]); errors_o++;
          end
          if (m_axis_tdata[139:96] !== e.ev) begin
            $error("out_event_ts exp %0d got %0d", e.ev, m_axis_tdata[139:96]); errors_o++;
          end
          if (m_axis_tdata[140] !== e.line) begin
            $error("out_feed exp %0d got %0d", e.line, m_axis_tdata[140]); errors_o++;
          end
          if (m_axis_tdata[156:141] !== e.hnd) begin
            $error("out_handle exp %0d got %0d", e.hnd, m_axis_tdata[156:141]); errors_o++;
          end
          if (m_axis_tuser !== e.gap) begin
            $error("gap exp %0d got %0d", e.gap, m_axis_tuser); errors_o++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last exp %0d got %0d", e.last, m_axis_tlast); errors_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == RegStartSeq) resync(cfg_data_i);
        else if (cfg_idx_i == RegPeerWait) hold_ms = cfg_data_i[WaitW-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) step(s_axis_tuser, s_axis_tdata);
    end
  end
endmodule

@@ verif/ab_feed_arbiter_reorder_tb.sv @@
// Testbench top for the A/B feed arbiter: clock, reset, stimulus and verdict.
// Depends on abfa_pkg, ab_feed_arbiter_reorder and abfa_checker.
`timescale 1ns / 1ps
module ab_feed_arbiter_reorder_tb;
  import abfa_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [InDataW-1:0]    s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OutDataW-1:0]   m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx = '0;
  logic [CfgDataW-1:0]   cfg_data = '0;
  int                    pending;
  int                    errors;
  int                    released;
  bit                    quiet = 0;
  logic [SeqW-1:0]       base;
  logic [WaitW-1:0]      hold_ms;
  int                    words;

  always #5 clk_i = ~clk_i;

  ab_feed_arbiter_reorder i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser), .m_axis_tlast(m_tlast),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  abfa_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser), .m_axis_tlast(m_tlast),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .pending_o(pending), .errors_o(errors), .released_o(released)
  );

  always @(posedge clk_i) m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send(input logic op, input logic [SeqW-1:0] seq, input logic [SeqW-1:0] fseq,
                      input logic [EvW-1:0] ev, input logic [RecvW-1:0] rv,
                      input logic feed, input logic [HndW-1:0] hnd);
    s_tuser <= op;
    s_tdata <= {7'b0, hnd, feed, rv, ev, fseq, seq};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    words++;
    if (!quiet && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 22);
    end
  endtask

  task automatic tick();
    send(OpTick, SeqW'(rnd64()), SeqW'(rnd64()), EvW'(rnd64()), RecvW'(rnd64()),
         1'($urandom()), HndW'($urandom()));
  endtask

  task automatic upd(input logic [SeqW-1:0] seq, input logic [EvW-1:0] ev,
                     input logic [RecvW-1:0] rv, input logic feed);
    send(OpUpdate, seq, SeqW'(rnd64()), ev, rv, feed, HndW'($urandom()));
  endtask

  // drain, let any gap search finish, then write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == RegStartSeq) base = val;
    else hold_ms = val[WaitW-1:0];
  endtask

  // one group of sequences, most with both feed copies, some missing, plus noise and ticks
  task automatic group(input int n);
    logic [EvW-1:0]   ev;
    logic [RecvW-1:0] rv;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) continue;
      ev = EvW'($urandom_range(4095));
      rv = RecvW'($urandom_range(255));
      upd(base + SeqW'(i), ev, rv, r[0]);
      if (r < 75) upd(base + SeqW'(i), ev + EvW'($urandom_range(1)) - EvW'($urandom_range(1)),
                      rv + RecvW'($urandom_range(2)) - 1'b1, ~r[0]);
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(2))
          0: upd(base - 1'b1 - SeqW'($urandom_range(70)), EvW'(rnd64()), RecvW'(rnd64()),
                 1'($urandom()));
          1: upd(base + SeqW'(WINDOW) + SeqW'($urandom_range(200)), EvW'(rnd64()),
                 RecvW'(rnd64()), 1'($urandom()));
          default: send(OpUpdate, SeqW'(rnd64()), SeqW'(rnd64()), EvW'(rnd64()),
                        RecvW'(rnd64()), 1'($urandom()), HndW'($urandom()));
        endcase
      end
    end
    repeat ($urandom_range(hold_ms > 20 ? 3 : hold_ms + 2)) tick();
    base = base + SeqW'(n);
  endtask

  initial begin
    base = 1;
    hold_ms = 5;
    words = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // duplicate rules: newer event, earlier receive, A over B on a full tie
    upd(1, 100, 50, 1'b1);
    upd(1, 101, 60, 1'b1);
    upd(1, 101, 40, 1'b1);
    upd(1, 101, 40, 1'b0);
    upd(1, 101, 40, 1'b1);
    upd(1, 99, 10, 1'b0);
    repeat (5) tick();
    upd(0, 1, 1, 1'b0);
    upd(SeqW'(2 + WINDOW), 1, 1, 1'b0);
    upd(SeqW'(1 + WINDOW), 1, 1, 1'b0);
    send(OpUpdate, 4, '1, '1, '1, 1'b1, '1);
    send(OpUpdate, 5, '0, '0, '0, 1'b0, '0);
    repeat (2) tick();
    write_reg(RegStartSeq, 48'hFFFF_FFFF_FFFE);
    write_reg(RegPeerWait, CfgDataW'(0));
    upd(48'hFFFF_FFFF_FFFE, 7, 7, 1'b1);
    upd(0, 7, 7, 1'b0);
    upd('1, 7, 7, 1'b0);
    tick();

    // long run: head waits while the window fills
    write_reg(RegStartSeq, 48'h8000_0000_0000);
    write_reg(RegPeerWait, CfgDataW'(20));
    for (int i = 0; i < WINDOW; i++)
      upd(base + SeqW'(i), EvW'($urandom()), RecvW'($urandom()), 1'($urandom()));
    repeat (21) tick();
    write_reg(RegStartSeq, base + SeqW'(WINDOW));

    quiet = 1;
    for (int g = 0; g < 3; g++) group($urandom_range(2, 6));
    quiet = 0;
    write_reg(RegPeerWait, CfgDataW'(1000));
    group($urandom_range(2, 6));
    write_reg(RegStartSeq, CfgDataW'(rnd64()));
    write_reg(RegPeerWait, CfgDataW'($urandom_range(1, 7)));
    for (int g = 0; g < 2; g++) group($urandom_range(1, 8));
    write_reg(RegPeerWait, CfgDataW'(0));
    write_reg(RegStartSeq, CfgDataW'(rnd64()));
    while (words < 160) group($urandom_range(1, 6));

    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("%0d words sent incl. ticks, %0d released; config extremes, wrap, gaps and",
             words, released);
    $display("duplicate tie rules exercised with random idle on both sides");
    if (errors == 0) $display("ab_feed_arbiter_reorder_tb: clean");
    else $display("ab_feed_arbiter_reorder_tb: errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("ab_feed_arbiter_reorder_tb: errors");
    $finish;
  end
endmodule
